@@ rtl/resol_pkg.sv @@
// ----------------------------------------------------------------------------
// resol_pkg
// Shared constants and types for the ring entry store with offset lookup.
// ----------------------------------------------------------------------------
package resol_pkg;

  // Ring geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;
  localparam int OFFS_W   = 20;
  localparam int SLOT_W   = 4;

  // Item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  // Search token walking from cell to cell
  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  remain;
    logic [OFFS_W-1:0] sum;
    logic [OFFS_W-1:0] offset;
  } tok_t;

  // Find result raised by a cell; payload fields are zero unless hit
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [SIZE_W-1:0]   byte_offset;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } res_t;

endpackage

@@ rtl/resol_cell.sv @@
// ----------------------------------------------------------------------------
// resol_cell
// One ring entry: holds a handle and a size, and checks the search token
// that passes through it, handing it on to the next cell on a miss.
// ----------------------------------------------------------------------------
module resol_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [resol_pkg::IDX_W-1:0]   cell_idx,
  input  logic                          wr_en,
  input  logic [resol_pkg::HANDLE_W-1:0] wr_handle,
  input  logic [resol_pkg::SIZE_W-1:0]  wr_size,
  input  resol_pkg::tok_t               tok_in,
  output resol_pkg::tok_t               tok_out,
  output resol_pkg::res_t               res,
  output logic [resol_pkg::HANDLE_W-1:0] rd_handle
);

  logic [resol_pkg::HANDLE_W-1:0] handle_r;
  logic [resol_pkg::SIZE_W-1:0]   size_r;
  resol_pkg::tok_t                tok_r;
  logic [resol_pkg::OFFS_W:0]     sum_nxt;
  logic                           tok_end;
  logic                           tok_hit;

  // Store the entry on an add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else if (wr_en) begin
      size_r <= wr_size;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      handle_r <= wr_handle;
    end
  end

  // Capture the token arriving from the neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  // Add this entry's size to the running sum and test against the offset
  always_comb begin
    sum_nxt = {1'b0, tok_r.sum} + (resol_pkg::OFFS_W + 1)'(size_r);
    tok_end = tok_r.valid && (tok_r.remain == '0);
    tok_hit = tok_r.valid && (tok_r.remain != '0) && (sum_nxt > {1'b0, tok_r.offset});
  end

  // Advance the token to the next cell when this entry does not match
  always_comb begin
    tok_out        = tok_r;
    tok_out.valid  = tok_r.valid && !tok_end && !tok_hit;
    tok_out.remain = tok_r.remain - 1'b1;
    tok_out.sum    = sum_nxt[resol_pkg::OFFS_W-1:0];
  end

  // Raise the result: a hit carries the entry, a miss carries only the valid flag
  always_comb begin
    res       = '0;
    res.valid = tok_end || tok_hit;
    if (tok_hit) begin
      res.hit         = 1'b1;
      res.slot        = resol_pkg::SLOT_W'(cell_idx);
      res.byte_offset = resol_pkg::SIZE_W'(tok_r.offset - tok_r.sum);
      res.handle      = handle_r;
      res.size        = size_r;
    end
  end

  assign rd_handle = handle_r;

endmodule

@@ rtl/ring_entry_store_offset_lookup.sv @@
// ----------------------------------------------------------------------------
// ring_entry_store_offset_lookup
// Ring of entries (handle, size) that overwrites the oldest when full, with
// lookup of the entry holding a given character of the joined entries.
// ----------------------------------------------------------------------------
// Add: result beat in the cycle after start; busy stays low, adds may follow
//   one another every cycle.
// Find: a token walks the cell chain from the oldest entry, one cell per
//   cycle; the result beat is registered from the cell where the token stops,
//   and busy is held until it stops. One find in flight at a time.
// Reset empties the ring and clears sizes; result beats cannot be stalled.
// ----------------------------------------------------------------------------
module ring_entry_store_offset_lookup (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [resol_pkg::HANDLE_W-1:0]  in_entry_handle,
  input  logic [resol_pkg::SIZE_W-1:0]    in_entry_size,
  input  logic [resol_pkg::OFFS_W-1:0]    in_char_offset,
  output logic                            out_strobe,
  output logic                            out_hit,
  output logic [resol_pkg::SLOT_W-1:0]    out_slot,
  output logic [resol_pkg::SIZE_W-1:0]    out_byte_offset,
  output logic [resol_pkg::HANDLE_W-1:0]  out_handle_out,
  output logic [resol_pkg::SIZE_W-1:0]    out_size_out,
  output logic                            out_evicted
);

  localparam int D = resol_pkg::DEPTH;

  logic [resol_pkg::IDX_W-1:0] wp_r, wp_nxt;
  logic [resol_pkg::IDX_W-1:0] rp_r, rp_nxt;
  logic                        full_r, full_nxt;
  logic                        busy_r, busy_nxt;

  logic                        accept;
  logic                        do_add;
  logic                        do_find;
  logic [resol_pkg::CNT_W-1:0] count;

  resol_pkg::tok_t             new_tok;
  resol_pkg::tok_t             tok_in  [D];
  resol_pkg::tok_t             tok_out [D];
  resol_pkg::res_t             cell_res [D];
  logic [resol_pkg::HANDLE_W-1:0] cell_handle [D];
  logic [D-1:0]                res_vld;
  logic [D-1:0]                tok_vld;
  resol_pkg::res_t             res_any;

  logic                           out_strobe_r, out_strobe_nxt;
  logic                           out_hit_r, out_hit_nxt;
  logic [resol_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [resol_pkg::SIZE_W-1:0]   out_byte_offset_r, out_byte_offset_nxt;
  logic [resol_pkg::HANDLE_W-1:0] out_handle_out_r, out_handle_out_nxt;
  logic [resol_pkg::SIZE_W-1:0]   out_size_out_r, out_size_out_nxt;
  logic                           out_evicted_r, out_evicted_nxt;

  function automatic logic [resol_pkg::IDX_W-1:0] ring_next(
    input logic [resol_pkg::IDX_W-1:0] p
  );
    if (p == resol_pkg::IDX_W'(D - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign accept  = start && !busy_r;
  assign do_add  = accept && (in_kind == resol_pkg::KIND_ADD);
  assign do_find = accept && (in_kind == resol_pkg::KIND_FIND);
  assign busy    = busy_r;

  // Number of stored entries
  always_comb begin
    if (full_r) begin
      count = resol_pkg::CNT_W'(D);
    end else if (wp_r >= rp_r) begin
      count = resol_pkg::CNT_W'(wp_r - rp_r);
    end else begin
      count = resol_pkg::CNT_W'(wp_r) + resol_pkg::CNT_W'(D) - resol_pkg::CNT_W'(rp_r);
    end
  end

  // Token for a new find, entered at the oldest entry
  always_comb begin
    new_tok        = '0;
    new_tok.valid  = 1'b1;
    new_tok.remain = count;
    new_tok.offset = in_char_offset;
  end

  // Cell chain, closed into a ring
  for (genvar i = 0; i < D; i++) begin : g_cell
    assign tok_in[i] = (do_find && (rp_r == resol_pkg::IDX_W'(i))) ? new_tok
                                                                     : tok_out[(i + D - 1) % D];
    assign res_vld[i] = cell_res[i].valid;
    assign tok_vld[i] = tok_out[i].valid;

    resol_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (resol_pkg::IDX_W'(i)),
      .wr_en     (do_add && (wp_r == resol_pkg::IDX_W'(i))),
      .wr_handle (in_entry_handle),
      .wr_size   (in_entry_size),
      .tok_in    (tok_in[i]),
      .tok_out   (tok_out[i]),
      .res       (cell_res[i]),
      .rd_handle (cell_handle[i])
    );
  end

  // Merge cell results; at most one cell raises one
  always_comb begin
    res_any = '0;
    for (int k = 0; k < D; k++) begin
      res_any = res_any | cell_res[k];
    end
  end

  // Pointers, full flag and busy
  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    full_nxt = full_r;
    busy_nxt = busy_r;
    if (do_add) begin
      wp_nxt = ring_next(wp_r);
      if (full_r) begin
        rp_nxt = ring_next(rp_r);
      end
      if (ring_next(wp_r) == (full_r ? ring_next(rp_r) : rp_r)) begin
        full_nxt = 1'b1;
      end
    end
    if (do_find) begin
      busy_nxt = 1'b1;
    end else if (res_any.valid) begin
      busy_nxt = 1'b0;
    end
  end

  // Result beat
  always_comb begin
    out_strobe_nxt      = 1'b0;
    out_hit_nxt         = 1'b0;
    out_slot_nxt        = '0;
    out_byte_offset_nxt = '0;
    out_handle_out_nxt  = '0;
    out_size_out_nxt    = '0;
    out_evicted_nxt     = 1'b0;
    if (do_add) begin
      out_strobe_nxt  = 1'b1;
      out_evicted_nxt = full_r;
      if (full_r) begin
        out_handle_out_nxt = cell_handle[rp_r];
      end
    end else if (res_any.valid) begin
      out_strobe_nxt      = 1'b1;
      out_hit_nxt         = res_any.hit;
      out_slot_nxt        = res_any.slot;
      out_byte_offset_nxt = res_any.byte_offset;
      out_handle_out_nxt  = res_any.handle;
      out_size_out_nxt    = res_any.size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      rp_r         <= '0;
      full_r       <= 1'b0;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      full_r       <= full_nxt;
      busy_r       <= busy_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r         <= out_hit_nxt;
    out_slot_r        <= out_slot_nxt;
    out_byte_offset_r <= out_byte_offset_nxt;
    out_handle_out_r  <= out_handle_out_nxt;
    out_size_out_r    <= out_size_out_nxt;
    out_evicted_r     <= out_evicted_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_byte_offset = out_byte_offset_r;
  assign out_handle_out  = out_handle_out_r;
  assign out_size_out    = out_size_out_r;
  assign out_evicted     = out_evicted_r;

  // Only one cell ends a walk at a time
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(res_vld))
    else $error("more than one cell raised a result");

  // A cell result only appears while a find is in flight
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld != '0) |-> busy_r)
    else $error("cell result without a find in flight");

  // No token moves along the chain while idle
  a_tok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_vld == '0))
    else $error("token in the chain while idle");

  // A full ring has its pointers together
  a_full_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (wp_r == rp_r))
    else $error("full ring with pointers apart");

endmodule
